// ===== rtl/core/moisture_pump_controller_defines.svh =====
// Assertion helpers shared by the controller modules.
// Each expects clk and arst_n in scope.
`ifndef MOISTURE_PUMP_CONTROLLER_DEFINES_SVH
`define MOISTURE_PUMP_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define MPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mpc_pkg.sv =====
package mpc_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int SECONDS_W   = 16;
	localparam int PHASE_W     = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PUMP_SECS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WAIT_SECS = 2'd2;

	localparam logic [SAMPLE_W-1:0]  THRESHOLD_RESET = 12'd2335;
	localparam logic [SECONDS_W-1:0] PUMP_SECS_RESET = 16'd2;
	localparam logic [SECONDS_W-1:0] WAIT_SECS_RESET = 16'd1800;

	// reported phase codes
	localparam logic [PHASE_W-1:0] PHASE_INIT  = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_CHECK = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_PUMP  = 2'd2;
	localparam logic [PHASE_W-1:0] PHASE_WAIT  = 2'd3;

	typedef enum logic [3:0] {
		ST_INIT  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_PUMP  = 4'b0100,
		ST_WAIT  = 4'b1000
	} fsm_state_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]  threshold;
		logic [SECONDS_W-1:0] pump_seconds;
		logic [SECONDS_W-1:0] wait_seconds;
	} cfg_t;

	function automatic logic [PHASE_W-1:0] phase_code(input fsm_state_t st);
		logic [PHASE_W-1:0] code;
		unique case (st)
			ST_INIT:  code = PHASE_INIT;
			ST_CHECK: code = PHASE_CHECK;
			ST_PUMP:  code = PHASE_PUMP;
			ST_WAIT:  code = PHASE_WAIT;
			default:  code = PHASE_INIT;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/core/mpc_filter.sv =====
`include "moisture_pump_controller_defines.svh"

module mpc_filter
	import mpc_pkg::*;
#(
	parameter int FRACTION_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [SAMPLE_W-1:0] threshold,
	output logic                above,
	output logic [SAMPLE_W-1:0] level
);

	localparam int AVG_W   = SAMPLE_W + FRACTION_BITS;
	// 49*avg + sample*2^F < 50*2^AVG_W < 2^(AVG_W+6)
	localparam int SUM_W   = AVG_W + 6;
	// divide by 50 as halve, then reciprocal multiply by 1/25
	localparam int HALF_W  = SUM_W - 1;
	localparam int SHIFT   = HALF_W + 5;
	localparam int RECIP_W = SHIFT - 4;
	localparam int PROD_W  = HALF_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'd24) / 64'd25;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	logic [AVG_W-1:0]  avg_q;
	logic              seeded_q;
	logic [AVG_W-1:0]  scaled;
	logic [SUM_W-1:0]  sum;
	logic [HALF_W-1:0] half;
	logic [PROD_W-1:0] prod;
	logic [AVG_W-1:0]  avg_next;

	assign scaled = {sample, {FRACTION_BITS{1'b0}}};
	assign sum    = (SUM_W'(avg_q) << 5) + (SUM_W'(avg_q) << 4) + SUM_W'(avg_q)
		+ SUM_W'(scaled);
	assign half   = sum[SUM_W-1:1];
	// exact floor(half/25): error term stays below 2^SHIFT
	assign prod   = PROD_W'(half) * PROD_W'(RECIP);
	assign avg_next = seeded_q ? prod[SHIFT +: AVG_W] : scaled;

	assign above = avg_next > {threshold, {FRACTION_BITS{1'b0}}};
	assign level = avg_q[AVG_W-1 -: SAMPLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q    <= '0;
			seeded_q <= 1'b0;
		end else if (advance) begin
			avg_q    <= avg_next;
			seeded_q <= 1'b1;
		end
	end

	`MPC_ASSERT_NEXT(a_avg_holds, !advance, $stable(avg_q), "average moved without a word")
	`MPC_ASSERT_NEXT(a_seed_once, advance, seeded_q, "filter not seeded after a word")

endmodule

// ===== rtl/core/mpc_fsm.sv =====
`include "moisture_pump_controller_defines.svh"

module mpc_fsm
	import mpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               tick,
	input  logic               above,
	input  cfg_t               cfg,
	output logic               pump_on,
	output logic [PHASE_W-1:0] phase
);

	fsm_state_t           state_q, state_d;
	logic [SECONDS_W-1:0] secs_q, secs_d, secs_ticked;
	logic                 pump_q, pump_d;

	// tick first, saturating at zero
	assign secs_ticked = (tick && secs_q != '0) ? secs_q - SECONDS_W'(1) : secs_q;

	always_comb begin
		state_d = state_q;
		secs_d  = secs_ticked;
		pump_d  = pump_q;
		unique case (state_q)
			ST_INIT: begin
				pump_d  = 1'b0;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (above) begin
					secs_d  = cfg.pump_seconds;
					state_d = ST_PUMP;
				end else begin
					secs_d  = cfg.wait_seconds;
					state_d = ST_WAIT;
				end
			end
			ST_PUMP: begin
				pump_d = 1'b1;
				if (secs_ticked == '0) begin
					pump_d  = 1'b0;
					secs_d  = cfg.wait_seconds;
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (secs_ticked == '0) state_d = ST_CHECK;
			end
			default: begin
				pump_d  = 1'b0;
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			secs_q  <= '0;
			pump_q  <= 1'b0;
		end else if (advance) begin
			state_q <= state_d;
			secs_q  <= secs_d;
			pump_q  <= pump_d;
		end
	end

	assign pump_on = pump_q;
	assign phase   = phase_code(state_q);

	`MPC_ASSERT_NOW(a_pump_in_pump, pump_q, state_q == ST_PUMP, "pump on outside pump phase")
	`MPC_ASSERT_NEXT(a_init_exit, advance && state_q == ST_INIT, state_q == ST_CHECK && !pump_q, "bad exit from init")
	`MPC_ASSERT_NEXT(a_check_load, advance && state_q == ST_CHECK, secs_q == ($past(above) ? $past(cfg.pump_seconds) : $past(cfg.wait_seconds)), "wrong count loaded on check")

endmodule

// ===== rtl/core/moisture_pump_controller.sv =====
// Moisture pump controller: low-pass filter on the sensor word, then one controller move.
// A word passes the input register, then the result register, on its way to result valid.
// Throughput: a word per cycle unless stalled; set by filter feedback's reciprocal multiply.
// Reset (arst_n low, asynchronous): filter unseeded, controller in init, pump off,
// registers back to threshold 2335, pump 2 s, wait 1800 s; no result pending.
module moisture_pump_controller
	import mpc_pkg::*;
#(
	parameter int FRACTION_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input word
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic [SAMPLE_W-1:0]    sample,
	input  logic                   second_tick,
	// result word
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic                   pump_on,
	output logic [PHASE_W-1:0]     phase,
	output logic [SAMPLE_W-1:0]    filtered_level
);

	cfg_t                cfg_q;

	// input register stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                tick_s1;

	logic                result_valid_q;
	logic                advance;
	logic                above;

	// config registers; index 3 is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= THRESHOLD_RESET;
			cfg_q.pump_seconds <= PUMP_SECS_RESET;
			cfg_q.wait_seconds <= WAIT_SECS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold    <= cfg_data[SAMPLE_W-1:0];
				REG_PUMP_SECS: cfg_q.pump_seconds <= cfg_data[SECONDS_W-1:0];
				REG_WAIT_SECS: cfg_q.wait_seconds <= cfg_data[SECONDS_W-1:0];
				default: ;
			endcase
		end
	end

	// The word in the input register moves into the result (state) registers
	// when the result slot is free or being emptied this cycle. The input
	// register takes a new word whenever it is empty or moving on, so one
	// word can wait here behind a stalled result.
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			sample_s1 <= sample;
			tick_s1   <= second_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

	// Filter and controller registers double as the result register: they
	// only change on advance, so a stalled result holds by construction.
	mpc_filter #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.sample    (sample_s1),
		.threshold (cfg_q.threshold),
		.above     (above),
		.level     (filtered_level)
	);

	mpc_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.tick    (tick_s1),
		.above   (above),
		.cfg     (cfg_q),
		.pump_on (pump_on),
		.phase   (phase)
	);

endmodule
